>>> src/jbce_pkg.sv
// shared types, constants and codes for the jtag blaster command encoder
`default_nettype none

package jbce_pkg;

    // largest shift and the fixed field widths
    localparam int MAX_BITS    = 64;
    localparam int MAX_BURST   = 63;
    localparam int BANG_LIMIT  = 11;
    localparam int RST_TICKS   = 5;
    localparam int BITS_W      = 7;
    localparam int PAD_W       = MAX_BITS + 1;
    localparam int AMT_W       = $clog2(MAX_BITS / 8 + 1);
    localparam int REM_W       = 4;
    localparam int CNT_W       = (AMT_W > REM_W) ? AMT_W : REM_W;
    localparam int TICK_W      = 3;
    localparam int REPLY_W     = 7;

    // operation codes
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [1:0] MODE_IR    = 2'd1;
    localparam logic [1:0] MODE_DR    = 2'd2;

    // command byte bits
    localparam logic [7:0] C_BMODE = 8'h80;
    localparam logic [7:0] C_READ  = 8'h40;
    localparam logic [7:0] C_LED   = 8'h20;
    localparam logic [7:0] C_TDI   = 8'h10;
    localparam logic [7:0] C_NCS   = 8'h08;
    localparam logic [7:0] C_TMS   = 8'h02;
    localparam logic [7:0] C_TCK   = 8'h01;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RST,
        ST_PRE,
        ST_NCS,
        ST_BHDR,
        ST_BDATA,
        ST_BANG,
        ST_POST
    } state_t;

    typedef enum logic [2:0] {
        BK_PIN,
        BK_NCS,
        BK_BHDR,
        BK_BDATA,
        BK_BANG
    } byte_kind_t;

    typedef struct packed {
        logic               load;
        logic               emit;
        byte_kind_t         kind;
        logic               tck;
        logic               tms;
        logic               led;
        logic               fin;
        logic [AMT_W-1:0]   amt;
        logic [REM_W-1:0]   rem;
    } dp_cmd_t;

    typedef struct packed {
        logic can_load;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> src/jtag_blaster_command_encoder.sv
// top level of the jtag blaster command encoder
//
// channel   direction  beat contents
// s_*       in         tuser: mode[1:0]; tdata: shift_data[63:0], bit_count[70:64], capture[71]
// m_*       out        tdata: cmd_byte[7:0], reply_bytes[14:8]; tlast: last
// cfg_*     in         cfg_data: burst_enable
//
// in idle the encoder takes an operation, then the byte sequencer issues one command byte
// per cycle while the output register is free or m_tready is high
// a new operation is taken only once the sequencer has issued the last byte of the
// previous one; an unused mode code is taken and produces no bytes
// m_tready low with a byte held holds the output register and pauses the sequencer
// reset leaves burst_enable set and the sequencer idle
`default_nettype none

module jtag_blaster_command_encoder (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [71:0]   s_tdata,   // shift_data[63:0], bit_count[70:64], capture[71]
    input  wire logic [1:0]    s_tuser,   // mode[1:0]
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata,   // cmd_byte[7:0], reply_bytes[14:8], zero[15]
    output logic               m_tlast,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic          cfg_data
);
    import jbce_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [7:0]           cmd_byte;
    logic [REPLY_W-1:0]   reply_bytes;

    jbce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tuser),
        .bit_count (s_tdata[70:64]),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd)
    );

    jbce_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .shift_data  (s_tdata[63:0]),
        .capture     (s_tdata[71]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd_byte    (cmd_byte),
        .last        (m_tlast),
        .reply_bytes (reply_bytes)
    );

    assign m_tdata = {1'b0, reply_bytes, cmd_byte};

endmodule

`default_nettype wire

>>> src/jbce_ctrl.sv
// byte sequencer state machine and burst planning for the command encoder
`default_nettype none

module jbce_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [1:0]        mode,
    input  wire logic [6:0]        bit_count,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    input  wire jbce_pkg::dp_stat_t stat,
    output jbce_pkg::dp_cmd_t      cmd
);
    import jbce_pkg::*;

    state_t              state_reg, state_next;
    logic                half_reg, half_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [AMT_W-1:0]    amt_reg, amt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                ir_reg, ir_next;
    logic                burst_reg;

    logic [BITS_W-1:0]   bits_sat;
    logic [BITS_W-1:0]   padded;
    logic [BITS_W-1:0]   pad_m1;
    logic                burst_sel;
    logic [AMT_W-1:0]    plan_amt;
    logic [REM_W-1:0]    plan_rem;
    logic [TICK_W-1:0]   pre_last;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);

    // burst planning: if chosen, a header sends whole bytes but the last 1-8 bits
    always_comb
    begin
        bits_sat  = (bit_count > BITS_W'(MAX_BITS)) ? BITS_W'(MAX_BITS) : bit_count;
        padded    = bits_sat + BITS_W'(1);
        pad_m1    = padded - BITS_W'(1);
        burst_sel = (burst_reg || (bits_sat > BITS_W'(BANG_LIMIT))) && (padded > BITS_W'(8));
        if (burst_sel)
        begin
            plan_amt = AMT_W'(pad_m1 >> 3);
            plan_rem = REM_W'({1'b0, pad_m1[2:0]}) + REM_W'(1);
        end
        else
        begin
            plan_amt = '0;
            plan_rem = REM_W'(padded);
        end
    end

    assign pre_last = ir_reg ? TICK_W'(2) : TICK_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            burst_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            half_reg  <= 1'b0;
            tick_reg  <= '0;
            cnt_reg   <= '0;
            amt_reg   <= '0;
            rem_reg   <= '0;
            ir_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            tick_reg  <= tick_next;
            cnt_reg   <= cnt_next;
            amt_reg   <= amt_next;
            rem_reg   <= rem_next;
            ir_reg    <= ir_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        tick_next  = tick_reg;
        cnt_next   = cnt_reg;
        amt_next   = amt_reg;
        rem_next   = rem_reg;
        ir_next    = ir_reg;
        cmd        = '0;
        cmd.kind   = BK_PIN;
        cmd.tck    = half_reg;
        cmd.amt    = plan_amt;
        cmd.rem    = plan_rem;
        cmd.emit   = (state_reg != ST_IDLE) && stat.can_load;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    half_next = 1'b0;
                    tick_next = '0;
                    case (mode)
                        MODE_RESET:
                        begin
                            // load with an empty plan so the reply count reads zero
                            cmd.load   = 1'b1;
                            cmd.amt    = '0;
                            cmd.rem    = '0;
                            state_next = ST_RST;
                        end
                        MODE_IR, MODE_DR:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_PRE;
                            ir_next    = (mode == MODE_IR);
                            amt_next   = plan_amt;
                            rem_next   = plan_rem;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RST:
            begin
                cmd.tms = (tick_reg != TICK_W'(RST_TICKS));
                cmd.led = (tick_reg != TICK_W'(RST_TICKS));
                cmd.fin = (tick_reg == TICK_W'(RST_TICKS)) && half_reg;
                if (cmd.emit)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (tick_reg == TICK_W'(RST_TICKS))
                            state_next = ST_IDLE;
                        else
                            tick_next = tick_reg + TICK_W'(1);
                    end
                end
            end
            ST_PRE:
            begin
                cmd.led = 1'b1;
                cmd.tms = (tick_reg != pre_last);
                if (cmd.emit)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (tick_reg == pre_last)
                            state_next = ST_NCS;
                        else
                            tick_next = tick_reg + TICK_W'(1);
                    end
                end
            end
            ST_NCS:
            begin
                cmd.kind = BK_NCS;
                if (cmd.emit)
                begin
                    if (amt_reg != '0)
                    begin
                        state_next = ST_BHDR;
                        cnt_next   = CNT_W'(amt_reg);
                    end
                    else
                    begin
                        state_next = ST_BANG;
                        cnt_next   = CNT_W'(rem_reg);
                    end
                end
            end
            ST_BHDR:
            begin
                cmd.kind = BK_BHDR;
                if (cmd.emit)
                    state_next = ST_BDATA;
            end
            ST_BDATA:
            begin
                cmd.kind = BK_BDATA;
                if (cmd.emit)
                begin
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_BANG;
                        cnt_next   = CNT_W'(rem_reg);
                    end
                    else
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
            end
            ST_BANG:
            begin
                cmd.kind = BK_BANG;
                cmd.led  = 1'b1;
                cmd.tms  = (cnt_reg == CNT_W'(1));
                if (cmd.emit)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (cnt_reg == CNT_W'(1))
                        begin
                            state_next = ST_POST;
                            tick_next  = '0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                end
            end
            ST_POST:
            begin
                cmd.led = (tick_reg == '0);
                cmd.tms = (tick_reg == '0);
                cmd.fin = (tick_reg == TICK_W'(1)) && half_reg;
                if (cmd.emit)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (tick_reg == TICK_W'(1))
                            state_next = ST_IDLE;
                        else
                            tick_next = tick_reg + TICK_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.can_load)
        else $error("byte issued while the output register is occupied");

    a_fin_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (state_reg == ST_POST || state_reg == ST_RST) && half_reg)
        else $error("final byte outside a closing tick");

    a_reset_op: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && mode == MODE_RESET) |=> state_reg == ST_RST)
        else $error("tap reset operation not started");

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BANG || state_reg == ST_BDATA) |-> cnt_reg != '0)
        else $error("shift counter empty while shifting");

endmodule

`default_nettype wire

>>> src/jbce_dpath.sv
// shift register, reply count and output register for the command encoder
`default_nettype none

module jbce_dpath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [jbce_pkg::MAX_BITS-1:0]     shift_data,
    input  wire logic                              capture,
    input  wire jbce_pkg::dp_cmd_t                 cmd,
    output jbce_pkg::dp_stat_t                     stat,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [7:0]                             cmd_byte,
    output logic                                   last,
    output logic [jbce_pkg::REPLY_W-1:0]           reply_bytes
);
    import jbce_pkg::*;

    logic [PAD_W-1:0]     sr_reg;
    logic                 read_reg;
    logic [AMT_W-1:0]     amt_reg;
    logic [REPLY_W-1:0]   reply_reg;
    logic                 out_valid_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic [REPLY_W-1:0]   out_reply_reg;
    logic [7:0]           byte_next;

    assign stat.can_load = !out_valid_reg || m_tready;

    always_comb
    begin
        byte_next = 8'h00;
        case (cmd.kind)
            BK_PIN:
            begin
                byte_next = (cmd.led ? C_LED : 8'h00) | (cmd.tms ? C_TMS : 8'h00)
                          | (cmd.tck ? C_TCK : 8'h00);
            end
            BK_NCS:
            begin
                byte_next = C_LED | C_NCS;
            end
            BK_BHDR:
            begin
                byte_next = C_BMODE | (read_reg ? C_READ : 8'h00) | 8'(amt_reg);
            end
            BK_BDATA:
            begin
                byte_next = sr_reg[7:0];
            end
            BK_BANG:
            begin
                // read flag only rides on the tck high half
                byte_next = C_LED | (sr_reg[0] ? C_TDI : 8'h00)
                          | ((read_reg && cmd.tck) ? C_READ : 8'h00)
                          | (cmd.tms ? C_TMS : 8'h00) | (cmd.tck ? C_TCK : 8'h00);
            end
            default:
            begin
                byte_next = 8'h00;
            end
        endcase
    end

    // padded stream: zero pad bit ahead of the data
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sr_reg    <= {shift_data, 1'b0};
            read_reg  <= capture;
            amt_reg   <= cmd.amt;
            reply_reg <= capture ? (REPLY_W'(cmd.amt) + REPLY_W'(cmd.rem)) : '0;
        end
        else if (cmd.emit && cmd.kind == BK_BDATA)
        begin
            sr_reg <= sr_reg >> 8;
        end
        else if (cmd.emit && cmd.kind == BK_BANG && cmd.tck)
        begin
            sr_reg <= sr_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            byte_reg      <= byte_next;
            last_reg      <= cmd.fin;
            out_reply_reg <= cmd.fin ? reply_reg : '0;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign cmd_byte    = byte_reg;
    assign last        = last_reg;
    assign reply_bytes = out_reply_reg;

endmodule

`default_nettype wire
